@@ rtl/lmg_pkg.sv @@
// Shared types, codes and helper functions for the locomotion mode guard.
// No dependencies; imported by locomotion_mode_guard_unit.
`default_nettype none

package lmg_pkg;

    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned LIMIT_W  = 15;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned AXES     = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 56;

    typedef logic [MODE_W-1:0]         mode_t;
    typedef logic [CMD_W-1:0]          cmd_t;
    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic [LIMIT_W-1:0]        limit_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    localparam mode_t MODE_ESTOP      = 3'd0;
    localparam mode_t MODE_FREE       = 3'd1;
    localparam mode_t MODE_STAND_DOWN = 3'd2;
    localparam mode_t MODE_STAND_UP   = 3'd3;
    localparam mode_t MODE_BALANCE    = 3'd4;
    localparam mode_t MODE_MOVE       = 3'd5;

    localparam cmd_t CMD_SET_MODE  = 2'd0;
    localparam cmd_t CMD_SET_SPEED = 2'd1;
    localparam cmd_t CMD_READ_MODE = 2'd2;
    localparam cmd_t CMD_READ_SPEED = 2'd3;

    localparam cfg_idx_t CFG_LIMIT_FORWARD  = 2'd0;
    localparam cfg_idx_t CFG_LIMIT_SIDEWAYS = 2'd1;
    localparam cfg_idx_t CFG_LIMIT_TURN     = 2'd2;

    function automatic logic mode_valid(input mode_t m);
        mode_valid = (m <= MODE_MOVE);
    endfunction

    // fixed transitions of the mode graph
    function automatic logic table_step(input mode_t from, input mode_t to);
        logic ok;
        ok = 1'b0;
        case (from)
            MODE_ESTOP:      ok = (to == MODE_STAND_DOWN);
            MODE_FREE:       ok = (to == MODE_STAND_DOWN);
            MODE_STAND_DOWN: ok = (to == MODE_STAND_UP);
            MODE_STAND_UP:   ok = (to == MODE_BALANCE) || (to == MODE_STAND_DOWN);
            MODE_BALANCE:    ok = (to == MODE_MOVE) || (to == MODE_STAND_UP);
            MODE_MOVE:       ok = (to == MODE_BALANCE);
            default:         ok = 1'b0;
        endcase
        table_step = ok;
    endfunction

    function automatic speed_t clamp_mag(input speed_t v, input limit_t lim);
        logic signed [SPEED_W:0] v_ext;
        logic signed [SPEED_W:0] hi;
        logic signed [SPEED_W:0] lo;
        speed_t res;
        v_ext = {v[SPEED_W-1], v};
        hi    = $signed({2'b00, lim});
        lo    = -hi;
        if (v_ext > hi)
        begin
            res = hi[SPEED_W-1:0];
        end
        else if (v_ext < lo)
        begin
            res = lo[SPEED_W-1:0];
        end
        else
        begin
            res = v;
        end
        clamp_mag = res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/locomotion_mode_guard_unit.sv @@
// Locomotion mode guard: mode transition check, velocity clamp and read-clear logic.
// Depends on lmg_pkg.
//
// Takes one request per clock cycle while the output is not stalled. A request is
// captured in an input register, checked against the held mode and clamped in a
// single pass of logic, and the result is registered in the output register. Mode,
// previous mode, changed flag and held velocity update in that same pass, so every
// request sees the state left by the one before it. While a result waits, the input
// register can still take one request; the limits are written through the cfg port,
// which is always ready, and take effect from the next request.
`default_nettype none

module locomotion_mode_guard_unit
    import lmg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [LIMIT_W-1:0]    cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] wanted_mode, [18:3] speed_forward, [34:19] speed_sideways,
    // [50:35] turn_rate, [55:51] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  wire logic [CMD_W-1:0]      s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] accepted, [3:1] mode_now, [4] changed_flag, [20:5] out_forward,
    // [36:21] out_sideways, [52:37] out_turn, [55:53] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    limit_t limit_reg [AXES];

    logic   in_valid_reg;
    cmd_t   in_cmd_reg;
    mode_t  in_mode_reg;
    speed_t in_speed_reg [AXES];

    mode_t  cur_mode_reg,  cur_mode_next;
    mode_t  prev_mode_reg, prev_mode_next;
    logic   dirty_reg,     dirty_next;
    speed_t vel_reg [AXES];
    speed_t vel_next [AXES];

    logic   out_valid_reg;
    logic   res_accepted;
    logic   res_flag;
    speed_t res_vel [AXES];
    logic   out_accepted_reg;
    mode_t  out_mode_reg;
    logic   out_flag_reg;
    speed_t out_vel_reg [AXES];

    logic   advance;
    logic   take_in;
    logic   step;
    logic   mode_ok;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign step          = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                limit_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LIMIT_FORWARD:  limit_reg[0] <= cfg_data;
                CFG_LIMIT_SIDEWAYS: limit_reg[1] <= cfg_data;
                CFG_LIMIT_TURN:     limit_reg[2] <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_cmd_reg      <= s_axis_tuser;
            in_mode_reg     <= s_axis_tdata[2:0];
            in_speed_reg[0] <= s_axis_tdata[18:3];
            in_speed_reg[1] <= s_axis_tdata[34:19];
            in_speed_reg[2] <= s_axis_tdata[50:35];
        end
    end

    assign mode_ok = mode_valid(in_mode_reg) &&
                     ((in_mode_reg == MODE_ESTOP) || (in_mode_reg == MODE_FREE) ||
                      ((cur_mode_reg == MODE_FREE) && (in_mode_reg == prev_mode_reg)) ||
                      table_step(cur_mode_reg, in_mode_reg));

    always_comb
    begin
        cur_mode_next  = cur_mode_reg;
        prev_mode_next = prev_mode_reg;
        dirty_next     = dirty_reg;
        res_accepted   = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            vel_next[i] = vel_reg[i];
        end

        unique case (in_cmd_reg)
            CMD_SET_MODE:
            begin
                if (!mode_valid(in_mode_reg))
                begin
                    res_accepted = 1'b0;
                end
                else if (in_mode_reg != cur_mode_reg)
                begin
                    if (mode_ok)
                    begin
                        prev_mode_next = cur_mode_reg;
                        cur_mode_next  = in_mode_reg;
                        dirty_next     = 1'b1;
                        for (int i = 0; i < AXES; i++)
                        begin
                            vel_next[i] = '0;
                        end
                    end
                    else
                    begin
                        res_accepted = 1'b0;
                    end
                end
            end
            CMD_SET_SPEED:
            begin
                if (cur_mode_reg == MODE_MOVE)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        vel_next[i] = clamp_mag(in_speed_reg[i], limit_reg[i]);
                    end
                end
                else
                begin
                    res_accepted = 1'b0;
                    for (int i = 0; i < AXES; i++)
                    begin
                        vel_next[i] = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res_flag = dirty_next;
        for (int i = 0; i < AXES; i++)
        begin
            res_vel[i] = vel_next[i];
        end

        if (in_cmd_reg == CMD_READ_MODE)
        begin
            dirty_next = 1'b0;
        end
        if (in_cmd_reg == CMD_READ_SPEED)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                vel_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode_reg  <= MODE_STAND_DOWN;
            prev_mode_reg <= MODE_STAND_DOWN;
            dirty_reg     <= 1'b1;
            for (int i = 0; i < AXES; i++)
            begin
                vel_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            cur_mode_reg  <= cur_mode_next;
            prev_mode_reg <= prev_mode_next;
            dirty_reg     <= dirty_next;
            for (int i = 0; i < AXES; i++)
            begin
                vel_reg[i] <= vel_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_accepted_reg <= res_accepted;
            out_mode_reg     <= cur_mode_next;
            out_flag_reg     <= res_flag;
            for (int i = 0; i < AXES; i++)
            begin
                out_vel_reg[i] <= res_vel[i];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_vel_reg[2], out_vel_reg[1], out_vel_reg[0],
                            out_flag_reg, out_mode_reg, out_accepted_reg};

endmodule

`default_nettype wire
